// ===== hdl/chs_pkg.sv =====
// Shared widths, constants, word types and the arctangent table of the direction sampler.
package chs_pkg;

   // fraction widths and core precision
   localparam int IN_FRAC_BITS     = 16;
   localparam int OUT_FRAC_BITS    = 14;
   localparam int CORE_BITS        = 30;
   localparam int CORDIC_STEPS_DEF = 16;

   // datapath widths
   localparam int R_W        = IN_FRAC_BITS + 1;
   localparam int REM_W      = IN_FRAC_BITS + 2;
   localparam int QUO_W      = CORE_BITS;
   localparam int CW         = 33;
   localparam int SQ_N_W     = 2 * CORE_BITS + 1;
   localparam int SQ_R_W     = 2 * CORE_BITS + 2;
   localparam int ROOT_STEPS = CORE_BITS + 1;

   // limit gain 0.60725... in Q.30
   localparam logic signed [CW-1:0] GAIN_Q30 = 33'sd652032874;

   // region codes, in eighths of a turn
   localparam logic [2:0] REGION_RIGHT  = 3'd0;
   localparam logic [2:0] REGION_TOP    = 3'd2;
   localparam logic [2:0] REGION_LEFT   = 3'd4;
   localparam logic [2:0] REGION_BOTTOM = 3'd6;

   // quarter-turn codes
   localparam logic [1:0] QUAD_0 = 2'd0;
   localparam logic [1:0] QUAD_1 = 2'd1;
   localparam logic [1:0] QUAD_2 = 2'd2;
   localparam logic [1:0] QUAD_3 = 2'd3;

   typedef struct packed {
      logic             valid;
      logic             center;
      logic             neg;
      logic [2:0]       region;
      logic [R_W-1:0]   r;
      logic [REM_W-1:0] rem;
      logic [QUO_W-1:0] quo;
   } div_word_type;

   typedef struct packed {
      logic                 valid;
      logic                 center;
      logic [1:0]           quad;
      logic [R_W-1:0]       r;
      logic signed [CW-1:0] x;
      logic signed [CW-1:0] y;
      logic signed [CW-1:0] z;
   } rot_word_type;

   typedef struct packed {
      logic              valid;
      logic              center;
      logic [SQ_N_W-1:0] n;
      logic [SQ_R_W-1:0] res;
      logic [15:0]       ox;
      logic [15:0]       oy;
   } root_word_type;

   // arctangent of 2^-i in 2^-32 turn, rounded to nearest
   function automatic logic [31:0] atan_turn(input logic [4:0] i);
      logic [31:0] a;
      case (i)
         5'd0:    a = 32'h20000000;
         5'd1:    a = 32'h12E4051E;
         5'd2:    a = 32'h09FB385B;
         5'd3:    a = 32'h051111D4;
         5'd4:    a = 32'h028B0D43;
         5'd5:    a = 32'h0145D7E1;
         5'd6:    a = 32'h00A2F61E;
         5'd7:    a = 32'h00517C55;
         5'd8:    a = 32'h0028BE53;
         5'd9:    a = 32'h00145F2F;
         5'd10:   a = 32'h000A2F98;
         5'd11:   a = 32'h000517CC;
         5'd12:   a = 32'h00028BE6;
         5'd13:   a = 32'h000145F3;
         5'd14:   a = 32'h0000A2FA;
         5'd15:   a = 32'h0000517D;
         5'd16:   a = 32'h000028BE;
         5'd17:   a = 32'h0000145F;
         5'd18:   a = 32'h00000A30;
         5'd19:   a = 32'h00000518;
         5'd20:   a = 32'h0000028C;
         5'd21:   a = 32'h00000146;
         5'd22:   a = 32'h000000A3;
         5'd23:   a = 32'h00000051;
         5'd24:   a = 32'h00000029;
         5'd25:   a = 32'h00000014;
         5'd26:   a = 32'h0000000A;
         5'd27:   a = 32'h00000005;
         5'd28:   a = 32'h00000003;
         5'd29:   a = 32'h00000001;
         5'd30:   a = 32'h00000001;
         default: a = 32'h00000000;
      endcase
      return a;
   endfunction

endpackage

// ===== hdl/chs_div_cell.sv =====
// One restoring-division cell: decides one quotient bit and hands the remainder on.
module chs_div_cell (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  chs_pkg::div_word_type word_i,
   output chs_pkg::div_word_type word_o
);

   chs_pkg::div_word_type word_ff, word_in;
   logic                          take;
   logic [chs_pkg::REM_W-1:0]     diff;

   // trial subtract, then shift the remainder up for the next bit
   always_comb begin
      take    = word_i.rem >= {1'b0, word_i.r};
      diff    = take ? (word_i.rem - {1'b0, word_i.r}) : word_i.rem;
      word_in = word_i;
      word_in.rem = {diff[chs_pkg::REM_W-2:0], 1'b0};
      word_in.quo = {word_i.quo[chs_pkg::QUO_W-2:0], take};
   end

   // advance when the chain moves
   always_ff @(posedge clock) begin
      if (reset) begin
         word_ff.valid <= 1'b0;
      end else if (en) begin
         word_ff <= word_in;
      end
   end

   assign word_o = word_ff;

endmodule

// ===== hdl/chs_cordic_cell.sv =====
// One CORDIC rotation cell with a fixed shift and arctangent.
module chs_cordic_cell #(
   parameter int STEP = 0
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  chs_pkg::rot_word_type word_i,
   output chs_pkg::rot_word_type word_o
);

   localparam logic [31:0] ANGLE = chs_pkg::atan_turn(5'(STEP % 32));

   chs_pkg::rot_word_type                word_ff, word_in;
   logic signed [chs_pkg::CW-1:0]        xs, ys, ang;

   // rotate toward zero residual angle
   always_comb begin
      xs      = word_i.x >>> STEP;
      ys      = word_i.y >>> STEP;
      ang     = $signed({1'b0, ANGLE});
      word_in = word_i;
      if (!word_i.z[chs_pkg::CW-1]) begin
         word_in.x = word_i.x - ys;
         word_in.y = word_i.y + xs;
         word_in.z = word_i.z - ang;
      end else begin
         word_in.x = word_i.x + ys;
         word_in.y = word_i.y - xs;
         word_in.z = word_i.z + ang;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         word_ff.valid <= 1'b0;
      end else if (en) begin
         word_ff <= word_in;
      end
   end

   assign word_o = word_ff;

endmodule

// ===== hdl/chs_sqrt_cell.sv =====
// One integer square-root cell: tries one result bit and hands the rest on.
module chs_sqrt_cell #(
   parameter int STEP = 0
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  chs_pkg::root_word_type word_i,
   output chs_pkg::root_word_type word_o
);

   localparam int SHIFT = 2 * (chs_pkg::ROOT_STEPS - 1 - STEP);
   localparam logic [chs_pkg::SQ_R_W:0] BIT = (chs_pkg::SQ_R_W + 1)'(1) << SHIFT;

   chs_pkg::root_word_type       word_ff, word_in;
   logic [chs_pkg::SQ_R_W:0]     sum;
   logic [chs_pkg::SQ_R_W:0]     diff;

   // subtract the trial square where it fits
   always_comb begin
      sum     = {1'b0, word_i.res} + BIT;
      diff    = {2'b00, word_i.n} - sum;
      word_in = word_i;
      if ({2'b00, word_i.n} >= sum) begin
         word_in.n   = diff[chs_pkg::SQ_N_W-1:0];
         word_in.res = (word_i.res >> 1) + BIT[chs_pkg::SQ_R_W-1:0];
      end else begin
         word_in.res = word_i.res >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         word_ff.valid <= 1'b0;
      end else if (en) begin
         word_ff <= word_in;
      end
   end

   assign word_o = word_ff;

endmodule

// ===== hdl/cosine_hemisphere_sampler.sv =====
// Cosine-weighted hemisphere sampler: concentric disk map, CORDIC, square root, all in cell chains.
//
//   channel | dir | word
//   req_    | in  | sample_a, sample_b
//   rsp_    | out | dir_x, dir_y, dir_z
//
// One word is taken per cycle while the result register is free or taken; each word passes
// the front register, the divider chain, the phase register, the CORDIC chain, the multiply,
// round, square and lift registers, the root chain and the result register, in that order.
// Synchronous reset empties every stage. When the result register holds a
// word that is not taken, every stage holds in place together.
module cosine_hemisphere_sampler #(
   parameter int CORDIC_STEPS = chs_pkg::CORDIC_STEPS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [15:0] sample_a, [31:16] sample_b
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata    // [15:0] dir_x, [31:16] dir_y, [46:32] dir_z, [47] zero
);

   localparam int SX_W = chs_pkg::IN_FRAC_BITS + 3;
   localparam int CW   = chs_pkg::CW;
   localparam int PW   = chs_pkg::R_W + 1 + CW;
   localparam int RSH  = chs_pkg::CORE_BITS - chs_pkg::OUT_FRAC_BITS;
   localparam logic signed [SX_W-1:0] ONE_S = SX_W'(1) << chs_pkg::IN_FRAC_BITS;
   localparam logic signed [15:0] LIMIT = 16'(1) << chs_pkg::OUT_FRAC_BITS;

   logic en;

   // ---------------- front: region select ----------------
   logic signed [SX_W-1:0] sx, sy, rr, qq;
   logic [2:0]             region;
   chs_pkg::div_word_type  front_in;
   chs_pkg::div_word_type  div_chain [chs_pkg::QUO_W+1];

   always_comb begin
      sx = $signed({2'b00, req_tdata[15:0], 1'b0}) - ONE_S;
      sy = $signed({2'b00, req_tdata[31:16], 1'b0}) - ONE_S;
      if (sx >= -sy) begin
         if (sx > sy) begin
            rr = sx;  qq = sy;  region = chs_pkg::REGION_RIGHT;
         end else begin
            rr = sy;  qq = -sx; region = chs_pkg::REGION_TOP;
         end
      end else begin
         if (sx <= sy) begin
            rr = -sx; qq = -sy; region = chs_pkg::REGION_LEFT;
         end else begin
            rr = -sy; qq = sx;  region = chs_pkg::REGION_BOTTOM;
         end
      end
      front_in.valid  = req_tvalid;
      front_in.center = (sx == '0) && (sy == '0);
      front_in.neg    = qq[SX_W-1];
      front_in.region = region;
      front_in.r      = rr[chs_pkg::R_W-1:0];
      front_in.rem    = qq[SX_W-1] ? 18'(-qq) : 18'(qq);
      front_in.quo    = '0;
   end

   chs_pkg::div_word_type front_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff.valid <= 1'b0;
      end else if (en) begin
         front_ff <= front_in;
      end
   end
   assign div_chain[0] = front_ff;

   // ---------------- divider chain ----------------
   for (genvar g = 0; g < chs_pkg::QUO_W; g++) begin : g_div
      chs_div_cell u_cell (
         .clock  (clock),
         .reset  (reset),
         .en     (en),
         .word_i (div_chain[g]),
         .word_o (div_chain[g+1])
      );
   end

   // ---------------- phase: eighths plus fraction ----------------
   chs_pkg::div_word_type dq;
   logic [31:0]           phase;
   chs_pkg::rot_word_type rot_in, rot_ff;
   chs_pkg::rot_word_type rot_chain [CORDIC_STEPS+1];

   always_comb begin
      dq     = div_chain[chs_pkg::QUO_W];
      phase  = dq.neg ? ({dq.region, 29'd0} - {2'b00, dq.quo})
                      : ({dq.region, 29'd0} + {2'b00, dq.quo});
      rot_in.valid  = dq.valid;
      rot_in.center = dq.center;
      rot_in.quad   = phase[31:30];
      rot_in.r      = dq.r;
      rot_in.x      = chs_pkg::GAIN_Q30;
      rot_in.y      = '0;
      rot_in.z      = $signed({3'b000, phase[29:0]});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rot_ff.valid <= 1'b0;
      end else if (en) begin
         rot_ff <= rot_in;
      end
   end
   assign rot_chain[0] = rot_ff;

   // ---------------- CORDIC chain ----------------
   for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_rot
      chs_cordic_cell #(.STEP(g)) u_cell (
         .clock  (clock),
         .reset  (reset),
         .en     (en),
         .word_i (rot_chain[g]),
         .word_o (rot_chain[g+1])
      );
   end

   // ---------------- quarter turn and radius multiply ----------------
   chs_pkg::rot_word_type  rq;
   logic signed [CW-1:0]   cs, sn;
   logic signed [PW-1:0]   px_in, py_in, px_ff, py_ff;
   logic                   mul_valid_ff, mul_center_ff;

   always_comb begin
      rq = rot_chain[CORDIC_STEPS];
      case (rq.quad)
         chs_pkg::QUAD_0: begin cs = rq.x;  sn = rq.y;  end
         chs_pkg::QUAD_1: begin cs = -rq.y; sn = rq.x;  end
         chs_pkg::QUAD_2: begin cs = -rq.x; sn = -rq.y; end
         default:         begin cs = rq.y;  sn = -rq.x; end
      endcase
      px_in = $signed({1'b0, rq.r}) * cs;
      py_in = $signed({1'b0, rq.r}) * sn;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_valid_ff <= 1'b0;
      end else if (en) begin
         mul_valid_ff <= rq.valid;
      end
   end
   always_ff @(posedge clock) begin
      if (en) begin
         mul_center_ff <= rq.center;
         px_ff         <= px_in;
         py_ff         <= py_in;
      end
   end

   // ---------------- round to Q.30 ----------------
   localparam logic signed [PW-1:0] HALF_IN = PW'(1) << (chs_pkg::IN_FRAC_BITS - 1);
   logic signed [PW-1:0] pxr, pyr;
   logic signed [CW-1:0] xq_ff, yq_ff;
   logic                 xq_valid_ff, xq_center_ff;

   always_comb begin
      pxr = (px_ff + HALF_IN) >>> chs_pkg::IN_FRAC_BITS;
      pyr = (py_ff + HALF_IN) >>> chs_pkg::IN_FRAC_BITS;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         xq_valid_ff <= 1'b0;
      end else if (en) begin
         xq_valid_ff <= mul_valid_ff;
      end
   end
   always_ff @(posedge clock) begin
      if (en) begin
         xq_center_ff <= mul_center_ff;
         xq_ff        <= pxr[CW-1:0];
         yq_ff        <= pyr[CW-1:0];
      end
   end

   // ---------------- squares and output x, y ----------------
   localparam logic signed [CW-1:0] HALF_OUT = CW'(1) << (RSH - 1);
   logic signed [2*CW-1:0] sqx, sqy;
   logic signed [CW-1:0]   rxo, ryo;
   logic [15:0]            ox_in, oy_in;
   logic [62:0]            sqx_ff, sqy_ff;
   logic [15:0]            ox_ff, oy_ff;
   logic                   sq_valid_ff, sq_center_ff;

   always_comb begin
      sqx = xq_ff * xq_ff;
      sqy = yq_ff * yq_ff;
      rxo = (xq_ff + HALF_OUT) >>> RSH;
      ryo = (yq_ff + HALF_OUT) >>> RSH;
      if (rxo > CW'(LIMIT)) ox_in = LIMIT;
      else if (rxo < -CW'(LIMIT)) ox_in = -LIMIT;
      else ox_in = rxo[15:0];
      if (ryo > CW'(LIMIT)) oy_in = LIMIT;
      else if (ryo < -CW'(LIMIT)) oy_in = -LIMIT;
      else oy_in = ryo[15:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_valid_ff <= 1'b0;
      end else if (en) begin
         sq_valid_ff <= xq_valid_ff;
      end
   end
   always_ff @(posedge clock) begin
      if (en) begin
         sq_center_ff <= xq_center_ff;
         sqx_ff       <= sqx[62:0];
         sqy_ff       <= sqy[62:0];
         ox_ff        <= ox_in;
         oy_ff        <= oy_in;
      end
   end

   // ---------------- lift: 1 - x^2 - y^2, floored ----------------
   localparam logic signed [64:0] ONE_Q60 = 65'(1) << (2 * chs_pkg::CORE_BITS);
   logic signed [64:0]     rest;
   chs_pkg::root_word_type lift_in, lift_ff;
   chs_pkg::root_word_type root_chain [chs_pkg::ROOT_STEPS+1];

   always_comb begin
      rest = ONE_Q60 - $signed({2'b00, sqx_ff}) - $signed({2'b00, sqy_ff});
      lift_in.valid  = sq_valid_ff;
      lift_in.center = sq_center_ff;
      lift_in.n      = rest[64] ? '0 : rest[chs_pkg::SQ_N_W-1:0];
      lift_in.res    = '0;
      lift_in.ox     = ox_ff;
      lift_in.oy     = oy_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lift_ff.valid <= 1'b0;
      end else if (en) begin
         lift_ff <= lift_in;
      end
   end
   assign root_chain[0] = lift_ff;

   // ---------------- square-root chain ----------------
   for (genvar g = 0; g < chs_pkg::ROOT_STEPS; g++) begin : g_root
      chs_sqrt_cell #(.STEP(g)) u_cell (
         .clock  (clock),
         .reset  (reset),
         .en     (en),
         .word_i (root_chain[g]),
         .word_o (root_chain[g+1])
      );
   end

   // ---------------- output z and result register ----------------
   chs_pkg::root_word_type rz;
   logic [32:0]            zr;
   logic [14:0]            oz;
   logic [47:0]            rsp_data_in, rsp_data_ff;
   logic                   rsp_valid_ff;

   always_comb begin
      rz = root_chain[chs_pkg::ROOT_STEPS];
      zr = ({1'b0, rz.res[31:0]} + (33'(1) << (RSH - 1))) >> RSH;
      if (zr > 33'(LIMIT)) oz = LIMIT[14:0];
      else oz = zr[14:0];
      if (rz.center) begin
         rsp_data_in = {1'b0, LIMIT[14:0], 16'd0, 16'd0};
      end else begin
         rsp_data_in = {1'b0, oz, rz.oy, rz.ox};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= rz.valid;
      end
   end
   always_ff @(posedge clock) begin
      if (en) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // advance the whole chain unless a held result is waiting
   assign en         = !rsp_valid_ff || rsp_tready;
   assign req_tready = en;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// ===== sim/tb_cosine_hemisphere_sampler.sv =====
// Self-checking testbench of the cosine hemisphere sampler with a bit-exact direction predictor.
module tb_cosine_hemisphere_sampler;

   localparam int STEPS = chs_pkg::CORDIC_STEPS_DEF;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;

   logic [47:0] dir_queue[$];
   int          mismatch_count = 0;
   bit          quiet_mode = 1'b0;

   cosine_hemisphere_sampler #(.CORDIC_STEPS(STEPS)) DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   always #1 clock = ~clock;

   function automatic longint fl_shift(longint v, int s);
      return v >>> s;
   endfunction

   function automatic longint rnd_shift(longint v, int s);
      if (s == 0) return v;
      return (v + (longint'(1) << (s - 1))) >>> s;
   endfunction

   function automatic longint clip(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   function automatic longint unsigned int_sqrt(longint unsigned n);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv >>= 2;
      while (bitv != 0) begin
         if (n >= res + bitv) begin
            n -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   // compute the packed direction word for one sample pair
   function automatic logic [47:0] predict_dir(logic [15:0] sa, logic [15:0] sb);
      longint sx, sy, r, q, c, s, x, y, z, xq, yq, rest, ox, oy, oz, xs, ys;
      longint unsigned m, k;
      logic [31:0] phase;
      logic [1:0]  quad;
      longint limit;
      limit = longint'(1) << chs_pkg::OUT_FRAC_BITS;
      sx = 2 * longint'(sa) - (longint'(1) << chs_pkg::IN_FRAC_BITS);
      sy = 2 * longint'(sb) - (longint'(1) << chs_pkg::IN_FRAC_BITS);
      if (sx == 0 && sy == 0)
         return {1'b0, 15'(limit), 16'd0, 16'd0};
      if (sx >= -sy) begin
         if (sx > sy) begin r = sx; q = sy; k = chs_pkg::REGION_RIGHT; end
         else begin r = sy; q = -sx; k = chs_pkg::REGION_TOP; end
      end else begin
         if (sx <= sy) begin r = -sx; q = -sy; k = chs_pkg::REGION_LEFT; end
         else begin r = -sy; q = sx; k = chs_pkg::REGION_BOTTOM; end
      end
      m = (longint'(q < 0 ? -q : q) << 29) / r;
      phase = 32'(k * 64'd536870912);
      phase = (q < 0) ? phase - 32'(m) : phase + 32'(m);
      // rotate the quarter-turn residue
      quad = phase[31:30];
      z = longint'(phase[29:0]);
      x = 652032874;
      y = 0;
      for (int i = 0; i < STEPS; i++) begin
         xs = fl_shift(x, i);
         ys = fl_shift(y, i);
         if (z >= 0) begin
            x -= ys; y += xs; z -= longint'(chs_pkg::atan_turn(5'(i)));
         end else begin
            x += ys; y -= xs; z += longint'(chs_pkg::atan_turn(5'(i)));
         end
      end
      case (quad)
         chs_pkg::QUAD_0: begin c = x; s = y; end
         chs_pkg::QUAD_1: begin c = -y; s = x; end
         chs_pkg::QUAD_2: begin c = -x; s = -y; end
         default: begin c = y; s = -x; end
      endcase
      xq = rnd_shift(r * c, chs_pkg::IN_FRAC_BITS);
      yq = rnd_shift(r * s, chs_pkg::IN_FRAC_BITS);
      rest = (longint'(1) << (2 * chs_pkg::CORE_BITS)) - xq * xq - yq * yq;
      if (rest < 0) rest = 0;
      ox = clip(rnd_shift(xq, chs_pkg::CORE_BITS - chs_pkg::OUT_FRAC_BITS), -limit, limit);
      oy = clip(rnd_shift(yq, chs_pkg::CORE_BITS - chs_pkg::OUT_FRAC_BITS), -limit, limit);
      oz = clip(rnd_shift(longint'(int_sqrt(rest)),
                          chs_pkg::CORE_BITS - chs_pkg::OUT_FRAC_BITS), 0, limit);
      return {1'b0, 15'(oz), 16'(oy), 16'(ox)};
   endfunction

   // offer one sample pair and hold it until taken; drop valid only while idling
   task automatic send_sample(logic [15:0] sa, logic [15:0] sb);
      while (!quiet_mode && $urandom_range(99) < 6) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {sb, sa};
      dir_queue = {dir_queue, predict_dir(sa, sb)};
      do @(posedge clock); while (!req_tready);
   endtask

   // drive ready with random stalls, or always ready in quiet mode
   always @(posedge clock) begin
      if (reset) rsp_tready <= 1'b0;
      else rsp_tready <= quiet_mode || ($urandom_range(99) >= 6);
   end

   // compare each taken word with the oldest prediction
   always @(posedge clock) begin
      logic [47:0] want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (dir_queue.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) $display("unexpected word %h", rsp_tdata);
         end else begin
            want = dir_queue.pop_front();
            if (want !== rsp_tdata) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch x %h/%h y %h/%h z %h/%h (expected/actual)",
                     want[15:0], rsp_tdata[15:0], want[31:16], rsp_tdata[31:16],
                     want[47:32], rsp_tdata[47:32]);
            end
         end
      end
   end

   task automatic test_corners();
      logic [15:0] edges[5] = '{16'h0000, 16'h8000, 16'hFFFF, 16'h7FFF, 16'h8001};
      foreach (edges[i]) foreach (edges[j]) send_sample(edges[i], edges[j]);
   endtask

   task automatic test_diagonals();
      logic [15:0] v;
      for (int i = 0; i < 200; i++) begin
         v = 16'($urandom);
         case ($urandom_range(2))
            0: send_sample(v, v);
            1: send_sample(v, 16'h0000 - v);
            default: send_sample(v, 16'h8000 ^ 16'($urandom_range(3)));
         endcase
      end
   endtask

   task automatic test_random(int count);
      for (int i = 0; i < count; i++) send_sample(16'($urandom), 16'($urandom));
   endtask

   task automatic test_back_to_back();
      quiet_mode = 1'b1;
      test_random(250);
      quiet_mode = 1'b0;
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_corners();
      test_diagonals();
      test_random(350);
      test_back_to_back();
      test_random(250);
      req_tvalid <= 1'b0;
      while (dir_queue.size() != 0) @(posedge clock);
      repeat (100 + STEPS) @(posedge clock);
      if (mismatch_count == 0 && dir_queue.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   initial begin
      #200000;
      $display("CHECKS FAILED");
      $finish;
   end
endmodule

// ===== cosine_hemisphere_sampler.f =====
hdl/chs_pkg.sv
hdl/chs_div_cell.sv
hdl/chs_cordic_cell.sv
hdl/chs_sqrt_cell.sv
hdl/cosine_hemisphere_sampler.sv
sim/tb_cosine_hemisphere_sampler.sv
